@@ rtl/core/qte_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qte_pkg
// shared widths, constants and the cordic arctangent values for the
// quaternion to zyx euler angle pipeline
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int QW           = 32;   // quaternion component width
    localparam int PQW          = 34;   // q30 product width
    localparam int SW           = 37;   // sum width ahead of the cordic units
    localparam int CW           = 40;   // cordic x / y width
    localparam int ZW           = 34;   // cordic angle width, q30 radians
    localparam int NW           = 62;   // square root radicand width
    localparam int SQRT_STEPS   = NW / 2;
    localparam int RW           = SQRT_STEPS;     // square root result width
    localparam int REMW         = SQRT_STEPS + 4; // square root remainder width
    localparam int PITCH_W      = 15;
    localparam int ANGLE_W      = 16;
    localparam int PITCH_LIM    = 9002;
    localparam int ANGLE_LIM    = 18002;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SCALE_W      = 14;

    localparam logic signed [SW-1:0]      ONE_Q30     = SW'(64'sd1073741824);
    localparam logic signed [ZW-1:0]      HALF_PI_Q30 = ZW'(64'sd1686629713);
    localparam logic signed [SCALE_W-1:0] DEG100_SCALE = SCALE_W'(5730);
    localparam logic [NW-1:0]             ONE_Q60     = NW'(1) << 60;

    typedef logic signed [QW-1:0]  quat_t;
    typedef logic signed [PQW-1:0] prod_t;
    typedef logic signed [SW-1:0]  sum_t;
    typedef logic signed [CW-1:0]  cvec_t;
    typedef logic signed [ZW-1:0]  cang_t;

    function automatic prod_t mulq30(input quat_t a, input quat_t b);
        logic signed [2*QW-1:0] p;
        p = a * b;
        return prod_t'(p[2*QW-1:30]);
    endfunction

    function automatic cang_t atan_q30(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = ZW'(843314857);
            1:       v = ZW'(497837829);
            2:       v = ZW'(263043837);
            3:       v = ZW'(133525159);
            4:       v = ZW'(67021687);
            5:       v = ZW'(33543516);
            6:       v = ZW'(16775851);
            7:       v = ZW'(8388437);
            8:       v = ZW'(4194283);
            9:       v = ZW'(2097149);
            10:      v = ZW'(1048576);
            11:      v = ZW'(524288);
            12:      v = ZW'(262144);
            13:      v = ZW'(131072);
            14:      v = ZW'(65536);
            15:      v = ZW'(32768);
            16:      v = ZW'(16384);
            17:      v = ZW'(8192);
            18:      v = ZW'(4096);
            19:      v = ZW'(2048);
            20:      v = ZW'(1024);
            21:      v = ZW'(512);
            22:      v = ZW'(256);
            23:      v = ZW'(128);
            24:      v = ZW'(64);
            25:      v = ZW'(32);
            26:      v = ZW'(16);
            27:      v = ZW'(8);
            28:      v = ZW'(4);
            29:      v = ZW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/qte_cordic.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qte_cordic
// pipelined atan2 in vectoring mode, one iteration per stage, followed by
// scaling to hundredths of a degree with rounding and saturation
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int STEPS = qte_pkg::CORDIC_STEPS_DEF,
    parameter int LIM   = qte_pkg::ANGLE_LIM,
    parameter int OW    = qte_pkg::ANGLE_W
) (
    input  wire logic                  clk,
    input  wire qte_pkg::cvec_t        y_in,
    input  wire qte_pkg::cvec_t        x_in,
    output logic signed [OW-1:0]       angle
);
    import qte_pkg::*;

    localparam int PW = ZW + SCALE_W;
    localparam int MW = PW - 30;

    cvec_t x_reg [0:STEPS];
    cvec_t y_reg [0:STEPS];
    cang_t z_reg [0:STEPS];
    logic  zero_reg [0:STEPS];

    cvec_t pre_x;
    cvec_t pre_y;
    cang_t pre_z;

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic        [PW-1:0] mag;
    logic        [PW-1:0] rnd;
    logic        [MW-1:0] r_mag;
    logic        [MW-1:0] r_sat;
    logic signed [OW-1:0] angle_reg;
    logic signed [OW-1:0] angle_next;

    // quadrant fold for negative x
    always_comb
    begin
        pre_x = x_in;
        pre_y = y_in;
        pre_z = '0;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                pre_x = y_in;
                pre_y = -x_in;
                pre_z = HALF_PI_Q30;
            end
            else
            begin
                pre_x = -y_in;
                pre_y = x_in;
                pre_z = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= pre_x;
        y_reg[0]    <= pre_y;
        z_reg[0]    <= pre_z;
        zero_reg[0] <= (x_in == '0) && (y_in == '0);
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            if (y_reg[i] >= 0)
            begin
                x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] + atan_q30(i);
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                z_reg[i+1] <= z_reg[i] - atan_q30(i);
            end
        end
    end

    assign prod_next = zero_reg[STEPS] ? '0
                     : PW'(z_reg[STEPS]) * PW'(DEG100_SCALE);

    // round half away from zero, then clamp
    always_comb
    begin
        mag   = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);
        rnd   = mag + (PW'(1) << 29);
        r_mag = rnd[PW-1:30];
        r_sat = (r_mag > MW'(LIM)) ? MW'(LIM) : r_mag;
        angle_next = prod_reg[PW-1] ? OW'(-r_sat) : OW'(r_sat);
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        angle_reg <= angle_next;
    end

    assign angle = angle_reg;

endmodule
`default_nettype wire

@@ rtl/core/quaternion_to_euler_angles.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// q30 unit quaternion to zyx pitch, roll and yaw in hundredths of a degree
// ----------------------------------------------------------------------------
// usage:
//   a quaternion transfer happens on each clock edge with start high and busy
//   low; busy is always low, so a new quaternion can enter every cycle
//   each input gives exactly one result, shown for one cycle with done high;
//   angles_updated is low and all angles zero when quat_present was low
// pipeline: 3 product/sum/square stages, 31 square root stages (one result
//   bit each), then fold, CORDIC_STEPS iterations and 2 scaling stages in
//   the three atan2 units running side by side
// throughput: one quaternion per cycle
// reset: clears all stage valid bits, so no result appears until fed
// the receiver cannot stall; results leave in input order
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
    parameter int CORDIC_STEPS = qte_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire qte_pkg::quat_t                  quat_w,
    input  wire qte_pkg::quat_t                  quat_x,
    input  wire qte_pkg::quat_t                  quat_y,
    input  wire qte_pkg::quat_t                  quat_z,
    input  wire logic                            quat_present,
    output logic                                 done,
    output logic signed [qte_pkg::PITCH_W-1:0]   pitch_angle,
    output logic signed [qte_pkg::ANGLE_W-1:0]   roll_angle,
    output logic signed [qte_pkg::ANGLE_W-1:0]   yaw_angle,
    output logic                                 angles_updated
);
    import qte_pkg::*;

    localparam int SQ  = SQRT_STEPS;
    localparam int CL  = CORDIC_STEPS + 3;
    localparam int LAT = 6 + SQ + CORDIC_STEPS;

    logic in_xfer;

    // stage 1: products
    logic  v1_reg, p1_reg;
    prod_t wy_reg, xz_reg, yz_reg, wx_reg, xx_reg, yy_reg, xy_reg, wz_reg, ww_reg, zz_reg;

    // stage 2: sums
    logic  v2_reg, p2_reg;
    sum_t  s_full, s_sat;
    logic signed [QW-1:0] s2_reg;
    sum_t  rn2_reg, rd2_reg, yn2_reg, yd2_reg;
    sum_t  rn_next, rd_next, yn_next, yd_next;

    // stage 3 onward: square root pipe
    logic signed [2*QW-1:0] sq_full;
    logic                 sv_reg  [0:SQ];
    logic                 sp_reg  [0:SQ];
    logic [NW-1:0]        n_reg   [0:SQ];
    logic [REMW-1:0]      rem_reg [0:SQ];
    logic [RW-1:0]        res_reg [0:SQ];
    logic signed [QW-1:0] s_reg   [0:SQ];
    sum_t                 rn_reg  [0:SQ];
    sum_t                 rd_reg  [0:SQ];
    sum_t                 yn_reg  [0:SQ];
    sum_t                 yd_reg  [0:SQ];

    // valid and presence beside the atan2 units
    logic vd_reg [0:CL-1];
    logic pd_reg [0:CL-1];

    cvec_t pit_y, pit_x, rol_y, rol_x, yaw_y, yaw_x;
    logic signed [PITCH_W-1:0] pitch_raw;
    logic signed [ANGLE_W-1:0] roll_raw;
    logic signed [ANGLE_W-1:0] yaw_raw;

    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_xfer;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= quat_present;
        wy_reg <= mulq30(quat_w, quat_y);
        xz_reg <= mulq30(quat_x, quat_z);
        yz_reg <= mulq30(quat_y, quat_z);
        wx_reg <= mulq30(quat_w, quat_x);
        xx_reg <= mulq30(quat_x, quat_x);
        yy_reg <= mulq30(quat_y, quat_y);
        xy_reg <= mulq30(quat_x, quat_y);
        wz_reg <= mulq30(quat_w, quat_z);
        ww_reg <= mulq30(quat_w, quat_w);
        zz_reg <= mulq30(quat_z, quat_z);
    end

    // stage 2
    always_comb
    begin
        s_full  = (SW'(wy_reg) - SW'(xz_reg)) <<< 1;
        s_sat   = s_full;
        if (s_full > ONE_Q30)
        begin
            s_sat = ONE_Q30;
        end
        if (s_full < -ONE_Q30)
        begin
            s_sat = -ONE_Q30;
        end
        rn_next = (SW'(yz_reg) + SW'(wx_reg)) <<< 1;
        rd_next = ONE_Q30 - (SW'(xx_reg) <<< 1) - (SW'(yy_reg) <<< 1);
        yn_next = (SW'(xy_reg) + SW'(wz_reg)) <<< 1;
        yd_next = SW'(ww_reg) + SW'(xx_reg) - SW'(yy_reg) - SW'(zz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p2_reg  <= p1_reg;
        s2_reg  <= QW'(s_sat);
        rn2_reg <= rn_next;
        rd2_reg <= rd_next;
        yn2_reg <= yn_next;
        yd2_reg <= yd_next;
    end

    // stage 3: radicand for the cosine
    assign sq_full = s2_reg * s2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg[0] <= 1'b0;
        end
        else
        begin
            sv_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sp_reg[0]  <= p2_reg;
        n_reg[0]   <= ONE_Q60 - NW'(sq_full);
        rem_reg[0] <= '0;
        res_reg[0] <= '0;
        s_reg[0]   <= s2_reg;
        rn_reg[0]  <= rn2_reg;
        rd_reg[0]  <= rd2_reg;
        yn_reg[0]  <= yn2_reg;
        yd_reg[0]  <= yd2_reg;
    end

    // digit by digit square root, one result bit per stage
    for (genvar k = 0; k < SQ; k++)
    begin : g_sqrt
        logic [REMW-1:0] cur;
        logic [REMW-1:0] trial;
        logic            ge;

        assign cur   = {rem_reg[k][REMW-3:0], n_reg[k][NW-1:NW-2]};
        assign trial = REMW'({res_reg[k], 2'b01});
        assign ge    = cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k+1] <= 1'b0;
            end
            else
            begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sp_reg[k+1]  <= sp_reg[k];
            n_reg[k+1]   <= {n_reg[k][NW-3:0], 2'b00};
            rem_reg[k+1] <= ge ? (cur - trial) : cur;
            res_reg[k+1] <= {res_reg[k][RW-2:0], ge};
            s_reg[k+1]   <= s_reg[k];
            rn_reg[k+1]  <= rn_reg[k];
            rd_reg[k+1]  <= rd_reg[k];
            yn_reg[k+1]  <= yn_reg[k];
            yd_reg[k+1]  <= yd_reg[k];
        end
    end

    // atan2 units
    assign pit_y = CW'(s_reg[SQ]);
    assign pit_x = CW'(signed'({1'b0, res_reg[SQ]}));
    assign rol_y = CW'(rn_reg[SQ]);
    assign rol_x = CW'(rd_reg[SQ]);
    assign yaw_y = CW'(yn_reg[SQ]);
    assign yaw_x = CW'(yd_reg[SQ]);

    qte_cordic #(
        .STEPS (CORDIC_STEPS),
        .LIM   (PITCH_LIM),
        .OW    (PITCH_W)
    ) u_pitch (
        .clk   (clk),
        .y_in  (pit_y),
        .x_in  (pit_x),
        .angle (pitch_raw)
    );

    qte_cordic #(
        .STEPS (CORDIC_STEPS),
        .LIM   (ANGLE_LIM),
        .OW    (ANGLE_W)
    ) u_roll (
        .clk   (clk),
        .y_in  (rol_y),
        .x_in  (rol_x),
        .angle (roll_raw)
    );

    qte_cordic #(
        .STEPS (CORDIC_STEPS),
        .LIM   (ANGLE_LIM),
        .OW    (ANGLE_W)
    ) u_yaw (
        .clk   (clk),
        .y_in  (yaw_y),
        .x_in  (yaw_x),
        .angle (yaw_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg[0] <= 1'b0;
        end
        else
        begin
            vd_reg[0] <= sv_reg[SQ];
        end
    end

    always_ff @(posedge clk)
    begin
        pd_reg[0] <= sp_reg[SQ];
    end

    for (genvar j = 1; j < CL; j++)
    begin : g_dly
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vd_reg[j] <= 1'b0;
            end
            else
            begin
                vd_reg[j] <= vd_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            pd_reg[j] <= pd_reg[j-1];
        end
    end

    assign done           = vd_reg[CL-1];
    assign angles_updated = vd_reg[CL-1] && pd_reg[CL-1];
    assign pitch_angle    = angles_updated ? pitch_raw : '0;
    assign roll_angle     = angles_updated ? roll_raw  : '0;
    assign yaw_angle      = angles_updated ? yaw_raw   : '0;

`ifndef ASSERT_OFF
    a_latency : assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> ##LAT done)
        else $error("result missing after pipeline latency");

    a_upd_only_done : assert property (@(posedge clk) disable iff (!rst_n)
        angles_updated |-> done)
        else $error("angles_updated without result strobe");

    a_not_updated_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && !angles_updated) |->
            (pitch_angle == '0 && roll_angle == '0 && yaw_angle == '0))
        else $error("angles nonzero for absent quaternion");

    a_pitch_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch_angle <= PITCH_W'(PITCH_LIM) && pitch_angle >= -PITCH_W'(PITCH_LIM)))
        else $error("pitch outside range");
`endif

endmodule
`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// checks quaternion_to_euler_angles against a bit-exact fixed point model of
// the zyx angle math (q30 products, integer square root, vectoring cordic),
// with directed corner cases, random unit and raw quaternions, and idle gaps
// ----------------------------------------------------------------------------
module tb;
    import qte_pkg::*;

    localparam int STEPS = CORDIC_STEPS_DEF;

    typedef struct {
        quat_t w, x, y, z;
        logic  present;
    } quat_item_t;

    typedef struct {
        logic signed [PITCH_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] yaw;
        logic                      updated;
    } euler_t;

    class euler_scoreboard;
        euler_t  pending[$];
        int      errors;
        longint  atan_lut[30];

        function new();
            atan_lut = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149,
                         1048576, 524288, 262144, 131072, 65536,
                         32768, 16384, 8192, 4096, 2048,
                         1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
            errors = 0;
        endfunction

        function longint q30_mul(longint a, longint b);
            longint p;
            p = a * b;
            return p >>> 30;
        endfunction

        function longint int_sqrt(longint unsigned n);
            longint unsigned res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return longint'(res);
        endfunction

        function longint vector_angle(longint yv, longint xv);
            longint ang, t, xs, ys;
            ang = 0;
            if (xv == 0 && yv == 0) return 0;
            if (xv < 0)
            begin
                t = xv;
                if (yv >= 0)
                begin
                    xv = yv;
                    yv = -t;
                    ang = 1686629713;
                end
                else
                begin
                    xv = -yv;
                    yv = t;
                    ang = -1686629713;
                end
            end
            for (int i = 0; i < STEPS && i < 30; i++)
            begin
                xs = xv >>> i;
                ys = yv >>> i;
                if (yv >= 0)
                begin
                    xv = xv + ys;
                    yv = yv - xs;
                    ang = ang + atan_lut[i];
                end
                else
                begin
                    xv = xv - ys;
                    yv = yv + xs;
                    ang = ang - atan_lut[i];
                end
            end
            return ang;
        endfunction

        function longint centideg(longint ang, longint lim);
            longint t, mag, r;
            t = ang * 5730;
            mag = (t < 0) ? -t : t;
            r = (mag + (64'sd1 <<< 29)) >>> 30;
            if (t < 0) r = -r;
            if (r > lim) r = lim;
            if (r < -lim) r = -lim;
            return r;
        endfunction

        function void note_input(quat_item_t q);
            euler_t e;
            longint w, x, y, z, s, c, rn, rd, yn, yd, one;
            one = 64'sd1073741824;
            e = '{pitch: '0, roll: '0, yaw: '0, updated: 1'b0};
            if (q.present)
            begin
                w = q.w;
                x = q.x;
                y = q.y;
                z = q.z;
                s = 2 * (q30_mul(w, y) - q30_mul(x, z));
                if (s > one) s = one;
                if (s < -one) s = -one;
                c = int_sqrt(longint'(one * one - s * s));
                rn = 2 * (q30_mul(y, z) + q30_mul(w, x));
                rd = one - 2 * q30_mul(x, x) - 2 * q30_mul(y, y);
                yn = 2 * (q30_mul(x, y) + q30_mul(w, z));
                yd = q30_mul(w, w) + q30_mul(x, x) - q30_mul(y, y) - q30_mul(z, z);
                e.pitch   = PITCH_W'(centideg(vector_angle(s, c), PITCH_LIM));
                e.roll    = ANGLE_W'(centideg(vector_angle(rn, rd), ANGLE_LIM));
                e.yaw     = ANGLE_W'(centideg(vector_angle(yn, yd), ANGLE_LIM));
                e.updated = 1'b1;
            end
            pending.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_result(euler_t r);
            euler_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result", 1, 0);
                return;
            end
            e = pending.pop_front();
            if (r.pitch !== e.pitch) report("pitch_angle", r.pitch, e.pitch);
            if (r.roll !== e.roll) report("roll_angle", r.roll, e.roll);
            if (r.yaw !== e.yaw) report("yaw_angle", r.yaw, e.yaw);
            if (r.updated !== e.updated) report("angles_updated", r.updated, e.updated);
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    quat_t quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic quat_present = 1'b0;
    logic done;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle, yaw_angle;
    logic angles_updated;

    euler_scoreboard sb = new();
    int idle_pct = 0;

    quaternion_to_euler_angles u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .quat_present(quat_present), .done(done), .pitch_angle(pitch_angle),
        .roll_angle(roll_angle), .yaw_angle(yaw_angle), .angles_updated(angles_updated)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        euler_t r;
        quat_item_t q;
        if (rst_n && start && !busy)
        begin
            q = '{w: quat_w, x: quat_x, y: quat_y, z: quat_z, present: quat_present};
            sb.note_input(q);
        end
        if (rst_n && done)
        begin
            r = '{pitch: pitch_angle, roll: roll_angle, yaw: yaw_angle,
                  updated: angles_updated};
            sb.check_result(r);
        end
    end

    // one transfer, then an optional random gap
    task automatic send_quat(quat_item_t q);
        quat_w <= q.w;
        quat_x <= q.x;
        quat_y <= q.y;
        quat_z <= q.z;
        quat_present <= q.present;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic quat_item_t mk(longint w, longint x, longint y, longint z, bit p);
        mk = '{w: quat_t'(w), x: quat_t'(x), y: quat_t'(y), z: quat_t'(z), present: p};
    endfunction

    function automatic quat_item_t unit_quat();
        real a, b, c, d, n;
        a = ($urandom_range(2000000) - 1000000.0) / 1.0e6;
        b = ($urandom_range(2000000) - 1000000.0) / 1.0e6;
        c = ($urandom_range(2000000) - 1000000.0) / 1.0e6;
        d = ($urandom_range(2000000) - 1000000.0) / 1.0e6;
        case ($urandom_range(5))
            0:
            begin
                c = a;
                b = 0.0;
                d = 0.0;
            end   // pitch near +90
            1:
            begin
                c = -a;
                b = d;
            end   // pitch near -90
            default: ;
        endcase
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0e-3)
        begin
            a = 1.0;
            n = 1.0;
        end
        unit_quat = mk($rtoi(a / n * 1073741823.0) + $urandom_range(4) - 2,
                       $rtoi(b / n * 1073741823.0), $rtoi(c / n * 1073741823.0),
                       $rtoi(d / n * 1073741823.0), 1'b1);
    endfunction

    initial
    begin
        quat_item_t q;
        int pct[4] = '{0, 62, 0, 19};
        longint one, mx, mn, h;
        one = 1073741824;
        mx = 2147483647;
        mn = -2147483648;
        h = 759250125;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_quat(mk(one, 0, 0, 0, 1));
        send_quat(mk(mx, mx, mx, mx, 0));
        send_quat(mk(0, 0, 0, 0, 1));
        send_quat(mk(mx, mx, mx, mx, 1));
        send_quat(mk(mn, mn, mn, mn, 1));
        send_quat(mk(mx, mn, mx, mn, 1));
        send_quat(mk(mn, mx, mn, mx, 1));
        send_quat(mk(h, 0, h, 0, 1));
        send_quat(mk(h, 0, -h, 0, 1));
        send_quat(mk(0, one, 0, 0, 1));
        send_quat(mk(0, 0, one, 0, 1));
        send_quat(mk(0, 0, 0, one, 1));
        send_quat(mk(-one, 0, 0, 0, 1));
        send_quat(mk(h, h, 0, 0, 1));
        send_quat(mk(h, -h, 0, 0, 1));
        send_quat(mk(h, 0, 0, -h, 1));
        send_quat(mk(0, h, h, 0, 1));
        send_quat(mk(-1, -1, -1, -1, 1));
        send_quat(mk(1, 0, 0, 0, 1));
        send_quat(mk(mn, 0, 0, 0, 0));

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = pct[ph];
            for (int n = 0; n < 150; n++)
            begin
                case ($urandom_range(9))
                    0, 1: q = mk($signed($urandom), $signed($urandom), $signed($urandom),
                                 $signed($urandom), 1'b1);
                    2:
                    begin
                        q = mk($signed($urandom), $signed($urandom), $signed($urandom),
                               $signed($urandom), 1'b0);
                    end
                    default: q = unit_quat();
                endcase
                send_quat(q);
            end
            if (ph == 1) drain();
        end

        drain();
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("** quaternion_to_euler_angles: PASSED **");
        else
            $display("** quaternion_to_euler_angles: FAILED **");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("** quaternion_to_euler_angles: FAILED **");
        $finish;
    end
endmodule
